// ===== rtl/core/wwwa_pkg.sv =====
// Shared types, codes and match tables for the WWW-Authenticate field parser.
// No dependencies; imported by wwwa_step and the top level.
package wwwa_pkg;

	// Event kinds on the result channel
	localparam logic [2:0] KIND_SCHEME    = 3'd0;
	localparam logic [2:0] KIND_VALUE_BYTE = 3'd1;
	localparam logic [2:0] KIND_VALUE_END = 3'd2;
	localparam logic [2:0] KIND_STALE     = 3'd3;
	localparam logic [2:0] KIND_DONE      = 3'd4;

	// Parameter codes; stale and ignored are internal only
	localparam logic [2:0] PARAM_QOP     = 3'd5;
	localparam logic [2:0] PARAM_STALE   = 3'd6;
	localparam logic [2:0] PARAM_IGNORED = 3'd7;

	// Scheme and stale payload codes
	localparam logic [7:0] SCHEME_NONE   = 8'd0;
	localparam logic [7:0] SCHEME_BASIC  = 8'd1;
	localparam logic [7:0] SCHEME_DIGEST = 8'd2;
	localparam logic [7:0] STALE_FALSE   = 8'd0;
	localparam logic [7:0] STALE_TRUE    = 8'd1;
	localparam logic [7:0] STALE_INVALID = 8'd2;

	// Parse phases
	localparam logic [3:0] PH_LEAD      = 4'd0;
	localparam logic [3:0] PH_SCHEME    = 4'd1;
	localparam logic [3:0] PH_NAMESKIP  = 4'd2;
	localparam logic [3:0] PH_NAME      = 4'd3;
	localparam logic [3:0] PH_AFTERNAME = 4'd4;
	localparam logic [3:0] PH_VALSTART  = 4'd5;
	localparam logic [3:0] PH_QUOTED    = 4'd6;
	localparam logic [3:0] PH_BARE      = 4'd7;
	localparam logic [3:0] PH_STOP      = 4'd8;

	// Characters of interest
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	// Match tables, strings right-justified in 9 bytes
	localparam int NUM_KW = 7;
	localparam logic [71:0] KW_STR [NUM_KW] = '{
		72'("realm"), 72'("domain"), 72'("nonce"), 72'("opaque"),
		72'("algorithm"), 72'("qop"), 72'("stale")};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd5, 4'd6, 4'd5, 4'd6, 4'd9, 4'd3, 4'd5};
	localparam logic [71:0] SCH_STR [2] = '{72'("basic"), 72'("digest")};
	localparam logic [3:0] SCH_LEN [2] = '{4'd5, 4'd6};
	localparam logic [71:0] STL_STR [2] = '{72'("true"), 72'("false")};
	localparam logic [3:0] STL_LEN [2] = '{4'd4, 4'd5};

	typedef struct packed {
		logic       have;
		logic [2:0] kind;
		logic [2:0] pid;
		logic [7:0] payload;
		logic       vdone;
		logic       ovf;
	} wwwa_event_t;

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	// True when pos lies inside the string and its character equals lc
	function automatic logic char_hit(logic [71:0] s, logic [3:0] len, logic [3:0] pos,
			logic [7:0] lc);
		logic [3:0] idx;
		idx = len - pos - 4'd1;
		return (pos < len) ? (s[{idx[3:0], 3'b000} +: 8] == lc) : 1'b0;
	endfunction

	function automatic logic [3:0] pos_inc(logic [3:0] pos);
		return (pos != 4'hF) ? pos + 4'd1 : pos;
	endfunction

	function automatic logic [6:0] narrow_kw(logic [6:0] cands, logic [3:0] pos,
			logic [7:0] lc);
		logic [6:0] r;
		r = cands;
		for (int k = 0; k < NUM_KW; k++)
			if (!char_hit(KW_STR[k], KW_LEN[k], pos, lc)) r[k] = 1'b0;
		return r;
	endfunction

	function automatic logic [1:0] narrow_sch(logic [1:0] cands, logic [3:0] pos,
			logic [7:0] lc);
		logic [1:0] r;
		r = cands;
		for (int k = 0; k < 2; k++)
			if (!char_hit(SCH_STR[k], SCH_LEN[k], pos, lc)) r[k] = 1'b0;
		return r;
	endfunction

	function automatic logic [1:0] narrow_stl(logic [1:0] cands, logic [3:0] pos,
			logic [7:0] lc);
		logic [1:0] r;
		r = cands;
		for (int k = 0; k < 2; k++)
			if (!char_hit(STL_STR[k], STL_LEN[k], pos, lc)) r[k] = 1'b0;
		return r;
	endfunction

	function automatic logic [7:0] scheme_code(logic [1:0] cands, logic [3:0] pos);
		if (cands[0] && pos == SCH_LEN[0]) return SCHEME_BASIC;
		else if (cands[1] && pos == SCH_LEN[1]) return SCHEME_DIGEST;
		else return SCHEME_NONE;
	endfunction

	// First keyword that matched completely, else ignored
	function automatic logic [2:0] resolve_name(logic [6:0] cands, logic [3:0] pos);
		logic [2:0] r;
		r = PARAM_IGNORED;
		for (int k = NUM_KW - 1; k >= 0; k--)
			if (cands[k] && pos == KW_LEN[k]) r = 3'(k);
		return r;
	endfunction

	// Event that closes a value: value end for passed names, verdict for stale
	function automatic wwwa_event_t value_end(logic [2:0] cp, logic [1:0] st,
			logic [3:0] pos, logic vo);
		wwwa_event_t e;
		e = '0;
		if (cp <= PARAM_QOP) begin
			e.have = 1'b1;
			e.kind = KIND_VALUE_END;
			e.pid = cp;
			e.vdone = 1'b1;
			e.ovf = vo;
		end else if (cp == PARAM_STALE) begin
			e.have = 1'b1;
			e.kind = KIND_STALE;
			e.vdone = 1'b1;
			if (st[0] && pos == STL_LEN[0]) e.payload = STALE_TRUE;
			else if (st[1] && pos == STL_LEN[1]) e.payload = STALE_FALSE;
			else e.payload = STALE_INVALID;
		end
		return e;
	endfunction

endpackage

// ===== rtl/core/wwwa_step.sv =====
// Parse state and one-byte step logic of the WWW-Authenticate field parser.
// Depends on wwwa_pkg for codes, match tables and the event type.
module wwwa_step import wwwa_pkg::*; #(
	parameter int VALUE_COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  data_byte,
	input  logic        end_of_field,
	input  logic [7:0]  max_value_length,
	output wwwa_event_t ev
);

	localparam int CW = (VALUE_COUNT_BITS > 8) ? VALUE_COUNT_BITS : 8;
	localparam int CAP = (1 << VALUE_COUNT_BITS) - 1;

	logic [3:0]                  ph_q, n_ph;
	logic [6:0]                  kw_q, n_kw;
	logic [1:0]                  sc_q, n_sc;
	logic [3:0]                  mp_q, n_mp;
	logic [2:0]                  cp_q, n_cp;
	logic [VALUE_COUNT_BITS-1:0] vc_q, n_vc;
	logic                        vo_q, n_vo;
	logic [1:0]                  st_q, n_st;
	logic [CW-1:0]               lim;
	logic [7:0]                  lc;
	logic                        blank, crlf, take, fin;
	wwwa_event_t                 e;

	// Clip the limit to what the count can hold
	always_comb begin
		lim = (CW'(max_value_length) > CW'(CAP)) ? CW'(CAP) : CW'(max_value_length);
	end

	// Advance the parse by one byte
	always_comb begin
		n_ph = ph_q; n_kw = kw_q; n_sc = sc_q; n_mp = mp_q;
		n_cp = cp_q; n_vc = vc_q; n_vo = vo_q; n_st = st_q;
		e = '0;
		take = 1'b0;
		fin = 1'b0;
		lc = to_lower(data_byte);
		blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
		crlf = (data_byte == CH_CR) || (data_byte == CH_LF);

		unique case (ph_q)
			PH_LEAD: begin
				if (blank) begin
				end else if (crlf) begin
					e.have = 1'b1;
					e.kind = KIND_SCHEME;
					e.payload = SCHEME_NONE;
					n_ph = PH_STOP;
				end else begin
					n_sc = narrow_sch(2'b11, 4'd0, lc);
					n_mp = 4'd1;
					n_ph = PH_SCHEME;
				end
			end
			PH_SCHEME: begin
				if (blank || crlf) begin
					e.have = 1'b1;
					e.kind = KIND_SCHEME;
					e.payload = scheme_code(sc_q, mp_q);
					n_ph = blank ? PH_NAMESKIP : PH_STOP;
				end else begin
					n_sc = narrow_sch(sc_q, mp_q, lc);
					n_mp = pos_inc(mp_q);
				end
			end
			PH_NAMESKIP: begin
				if (blank || data_byte == CH_COMMA) begin
				end else if (data_byte == CH_EQ) begin
					n_cp = PARAM_IGNORED;
					n_vc = '0; n_vo = 1'b0; n_st = 2'b11; n_mp = 4'd0;
					n_ph = PH_VALSTART;
				end else if (crlf) begin
					n_ph = PH_STOP;
				end else begin
					n_kw = narrow_kw(7'h7F, 4'd0, lc);
					n_mp = 4'd1;
					n_ph = PH_NAME;
				end
			end
			PH_NAME: begin
				if (blank) begin
					n_cp = resolve_name(kw_q, mp_q);
					n_ph = PH_AFTERNAME;
				end else if (data_byte == CH_EQ) begin
					n_cp = resolve_name(kw_q, mp_q);
					n_vc = '0; n_vo = 1'b0; n_st = 2'b11; n_mp = 4'd0;
					n_ph = PH_VALSTART;
				end else if (crlf) begin
					n_ph = PH_STOP;
				end else begin
					n_kw = narrow_kw(kw_q, mp_q, lc);
					n_mp = pos_inc(mp_q);
				end
			end
			PH_AFTERNAME: begin
				if (blank) begin
				end else if (data_byte == CH_EQ) begin
					n_vc = '0; n_vo = 1'b0; n_st = 2'b11; n_mp = 4'd0;
					n_ph = PH_VALSTART;
				end else begin
					n_ph = PH_STOP;
				end
			end
			PH_VALSTART: begin
				if (blank) begin
				end else if (data_byte == CH_QUOTE) begin
					n_ph = PH_QUOTED;
				end else if (data_byte == CH_COMMA || crlf) begin
					fin = 1'b1;
					n_ph = (data_byte == CH_COMMA) ? PH_NAMESKIP : PH_STOP;
				end else begin
					take = 1'b1;
					n_ph = PH_BARE;
				end
			end
			PH_QUOTED: begin
				if (data_byte == CH_QUOTE) begin
					fin = 1'b1;
					n_ph = PH_NAMESKIP;
				end else begin
					take = 1'b1;
				end
			end
			PH_BARE: begin
				if (data_byte == CH_COMMA || blank || crlf) begin
					fin = 1'b1;
					n_ph = crlf ? PH_STOP : PH_NAMESKIP;
				end else begin
					take = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Pass, drop or match one value byte
		if (take) begin
			if (cp_q <= PARAM_QOP) begin
				if (CW'(vc_q) < lim) begin
					n_vc = vc_q + 1'b1;
					e.have = 1'b1;
					e.kind = KIND_VALUE_BYTE;
					e.pid = cp_q;
					e.payload = data_byte;
				end else begin
					n_vo = 1'b1;
				end
			end else if (cp_q == PARAM_STALE) begin
				n_st = narrow_stl(st_q, mp_q, lc);
				n_mp = pos_inc(mp_q);
			end
		end

		if (fin) e = value_end(cp_q, st_q, mp_q, vo_q);

		// Close out the field: report what is pending, then return to reset state
		if (end_of_field) begin
			if (n_ph == PH_LEAD || n_ph == PH_SCHEME) begin
				e = '0;
				e.have = 1'b1;
				e.kind = KIND_SCHEME;
				e.payload = (n_ph == PH_SCHEME) ? scheme_code(n_sc, n_mp) : SCHEME_NONE;
			end else if (n_ph == PH_VALSTART || n_ph == PH_QUOTED || n_ph == PH_BARE) begin
				if (e.have) begin
					e.vdone = 1'b1;
					e.ovf = n_vo;
				end else begin
					e = value_end(n_cp, n_st, n_mp, n_vo);
				end
			end
			if (!e.have) begin
				e = '0;
				e.have = 1'b1;
				e.kind = KIND_DONE;
			end
			n_ph = PH_LEAD; n_kw = 7'h7F; n_sc = 2'b11; n_mp = 4'd0;
			n_cp = 3'd0; n_vc = '0; n_vo = 1'b0; n_st = 2'b11;
		end
		ev = e;
	end

	// Hold parse state between beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_LEAD;
			kw_q <= 7'h7F;
			sc_q <= 2'b11;
			mp_q <= 4'd0;
			cp_q <= 3'd0;
			vc_q <= '0;
			vo_q <= 1'b0;
			st_q <= 2'b11;
		end else if (fire) begin
			ph_q <= n_ph;
			kw_q <= n_kw;
			sc_q <= n_sc;
			mp_q <= n_mp;
			cp_q <= n_cp;
			vc_q <= n_vc;
			vo_q <= n_vo;
			st_q <= n_st;
		end
	end

endmodule

// ===== rtl/core/www_authenticate_header_parser_core.sv =====
// Top level of the WWW-Authenticate field parser: input register, configuration
// register and result register around wwwa_step. Depends on wwwa_pkg and wwwa_step.
//
// Takes one header byte per beat and gives at most one event per byte. Throughput is one
// byte per cycle. The input register, the combinational match logic in wwwa_step and the
// result register form a two-stage pipe. A byte waits in the input register and its event
// is offered on the result side once loaded into the result register. A new byte is taken
// every cycle unless a held result blocks the result register. Bytes with no event pass through
// the input register but leave the result register alone. The byte with end_of_field
// always yields exactly one event with field_done set, and the parser then starts fresh.
// Write max_value_length only while the block is idle.
module www_authenticate_header_parser_core import wwwa_pkg::*; #(
	parameter int VALUE_COUNT_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_field,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_kind,
	output logic [2:0] param_id,
	output logic [7:0] payload,
	output logic       value_done,
	output logic       overflowed,
	output logic       field_done
);

	logic [7:0]  max_value_length_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        eof_s1;
	logic        advance;
	logic        out_valid_q;
	wwwa_event_t ev;
	wwwa_event_t ev_q;
	logic        fdone_q;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_length_q <= 8'd127;
		end else if (cfg_wr_en) begin
			max_value_length_q <= cfg_wr_data;
		end
	end

	// Input register: take a beat whenever the step can drain it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			eof_s1 <= end_of_field;
		end
	end

	wwwa_step #(
		.VALUE_COUNT_BITS(VALUE_COUNT_BITS)
	) u_step (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (advance),
		.data_byte       (data_s1),
		.end_of_field    (eof_s1),
		.max_value_length(max_value_length_q),
		.ev              (ev)
	);

	// Result register: load an event, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && ev.have) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ev.have) begin
			ev_q <= ev;
			fdone_q <= eof_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign event_kind = ev_q.kind;
	assign param_id = ev_q.pid;
	assign payload = ev_q.payload;
	assign value_done = ev_q.vdone;
	assign overflowed = ev_q.ovf;
	assign field_done = fdone_q;

	// Field end always produces an event
	a_eof_event: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eof_s1 |=> out_valid && field_done)
		else $error("field end gave no event");

	// Only value events carry a parameter id
	a_pid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != KIND_VALUE_BYTE && event_kind != KIND_VALUE_END
		|-> param_id == 3'd0)
		else $error("parameter id on a non-value event");

	// Value end and stale verdict always close the value
	a_vdone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == KIND_VALUE_END || event_kind == KIND_STALE)
		|-> value_done)
		else $error("value end without value_done");

	// A done-only event appears only at field end
	a_done_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == KIND_DONE |-> field_done)
		else $error("done event outside field end");

	// A blocked input beat holds its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_s1) && $stable(eof_s1))
		else $error("input register lost a stalled beat");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for www_authenticate_header_parser_core: header fields go in byte by byte, and
// every result beat is checked against an in-bench model of the parser.
// Depends on wwwa_pkg for the event, parameter, scheme, stale, phase and character codes.
module tb_top;
	import wwwa_pkg::*;

	localparam int VALUE_BITS = 8;
	localparam int PIPE_SETTLE = 4;
	localparam int LONG_HOLD = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_BYTES_PER_PHASE = 250;
	localparam int NUM_PHASES = 5;

	// Word groups for matching and for building fields
	localparam int GRP_SCHEME = 0;
	localparam int GRP_STALE = 1;
	localparam int GRP_KEYWORD = 2;

	typedef struct packed {
		logic       have;
		logic [2:0] kind;
		logic [2:0] pid;
		logic [7:0] pay;
		logic       vdone;
		logic       ovf;
		logic       fdone;
	} hdr_event_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       end_of_field;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] event_kind;
	logic [2:0] param_id;
	logic [7:0] payload;
	logic       value_done;
	logic       overflowed;
	logic       field_done;

	// Parser model state
	logic [7:0] value_limit;
	logic [3:0] scan_phase;
	logic [6:0] kw_set;
	logic [1:0] sch_set;
	logic [3:0] pos;
	logic [2:0] cur_param;
	int         val_cnt;
	logic       val_ovf;
	logic [1:0] stl_set;
	hdr_event_t step_event;

	hdr_event_t pending_events[$];
	logic [7:0] field_bytes[$];
	int         mismatches = 0;
	int         hold_cycles = 0;
	int         quiet_cycles = 0;
	bit         send_idle_en = 1'b1;
	bit         recv_idle_en = 1'b1;

	www_authenticate_header_parser_core #(.VALUE_COUNT_BITS(VALUE_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_field(end_of_field),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.param_id(param_id),
		.payload(payload),
		.value_done(value_done),
		.overflowed(overflowed),
		.field_done(field_done)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- parser model

	function automatic string word_of(int grp, int k);
		if (grp == GRP_SCHEME) begin
			if (k == 0) return "basic";
			return "digest";
		end
		if (grp == GRP_STALE) begin
			if (k == 0) return "true";
			return "false";
		end
		case (k)
			0: return "realm";
			1: return "domain";
			2: return "nonce";
			3: return "opaque";
			4: return "algorithm";
			5: return "qop";
			default: return "stale";
		endcase
	endfunction

	function automatic int word_len(int grp, int k);
		string w;
		w = word_of(grp, k);
		return w.len();
	endfunction

	// Drop candidates whose word differs at the current position, then advance it
	function automatic logic [6:0] prune(logic [6:0] cands, int grp, int n, logic [7:0] c);
		string w;
		logic [7:0] lc;
		logic [7:0] wc;
		lc = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
		for (int k = 0; k < n; k++) begin
			w = word_of(grp, k);
			if (cands[k]) begin
				if (int'(pos) >= w.len()) begin
					cands[k] = 1'b0;
				end else begin
					wc = w[pos];
					if (wc != lc) cands[k] = 1'b0;
				end
			end
		end
		if (pos != 4'hF) pos = pos + 4'd1;
		return cands;
	endfunction

	function automatic void restart_scan();
		scan_phase = PH_LEAD;
		kw_set = 7'h7F;
		sch_set = 2'b11;
		pos = 4'd0;
		cur_param = 3'd0;
		val_cnt = 0;
		val_ovf = 1'b0;
		stl_set = 2'b11;
	endfunction

	function automatic void post_event(logic [2:0] kind, logic [2:0] pid, logic [7:0] pay,
			logic vdone, logic ovf);
		step_event.have = 1'b1;
		step_event.kind = kind;
		step_event.pid = pid;
		step_event.pay = pay;
		step_event.vdone = vdone;
		step_event.ovf = ovf;
	endfunction

	// Report the scheme; only a fully matched token in the scheme phase counts
	function automatic void note_scheme();
		logic [7:0] code;
		code = SCHEME_NONE;
		if (scan_phase == PH_SCHEME) begin
			if (sch_set[0] && int'(pos) == word_len(GRP_SCHEME, 0)) code = SCHEME_BASIC;
			else if (sch_set[1] && int'(pos) == word_len(GRP_SCHEME, 1)) code = SCHEME_DIGEST;
		end
		post_event(KIND_SCHEME, 3'd0, code, 1'b0, 1'b0);
	endfunction

	// First keyword matched exactly, else ignored
	function automatic void settle_name();
		cur_param = PARAM_IGNORED;
		for (int k = 0; k < 7; k++) begin
			if (kw_set[k] && int'(pos) == word_len(GRP_KEYWORD, k)) begin
				cur_param = 3'(k);
				break;
			end
		end
	endfunction

	function automatic void open_value();
		val_cnt = 0;
		val_ovf = 1'b0;
		stl_set = 2'b11;
		pos = 4'd0;
	endfunction

	function automatic void take_value(logic [7:0] c);
		int lim;
		lim = int'(value_limit);
		if (lim > (1 << VALUE_BITS) - 1) lim = (1 << VALUE_BITS) - 1;
		if (cur_param <= PARAM_QOP) begin
			if (val_cnt < lim) begin
				val_cnt++;
				post_event(KIND_VALUE_BYTE, cur_param, c, 1'b0, 1'b0);
			end else begin
				val_ovf = 1'b1;
			end
		end else if (cur_param == PARAM_STALE) begin
			stl_set = 2'(prune(7'(stl_set), GRP_STALE, 2, c));
		end
	endfunction

	function automatic void close_value();
		logic [7:0] verdict;
		if (cur_param <= PARAM_QOP) begin
			post_event(KIND_VALUE_END, cur_param, 8'd0, 1'b1, val_ovf);
		end else if (cur_param == PARAM_STALE) begin
			verdict = STALE_INVALID;
			if (stl_set[0] && int'(pos) == word_len(GRP_STALE, 0)) verdict = STALE_TRUE;
			else if (stl_set[1] && int'(pos) == word_len(GRP_STALE, 1)) verdict = STALE_FALSE;
			post_event(KIND_STALE, 3'd0, verdict, 1'b1, 1'b0);
		end
	endfunction

	// Advance the model by one accepted byte and queue the event it causes
	function automatic void parse_header_byte(logic [7:0] c, logic eof);
		logic blank;
		logic crlf;
		blank = (c == CH_SPACE || c == CH_TAB);
		crlf = (c == CH_CR || c == CH_LF);
		step_event = '0;
		case (scan_phase)
			PH_LEAD: begin
				if (blank) begin
				end else if (crlf) begin
					note_scheme();
					scan_phase = PH_STOP;
				end else begin
					sch_set = 2'b11;
					pos = 4'd0;
					sch_set = 2'(prune(7'(sch_set), GRP_SCHEME, 2, c));
					scan_phase = PH_SCHEME;
				end
			end
			PH_SCHEME: begin
				if (blank || crlf) begin
					note_scheme();
					scan_phase = blank ? PH_NAMESKIP : PH_STOP;
				end else begin
					sch_set = 2'(prune(7'(sch_set), GRP_SCHEME, 2, c));
				end
			end
			PH_NAMESKIP: begin
				if (blank || c == CH_COMMA) begin
				end else if (c == CH_EQ) begin
					cur_param = PARAM_IGNORED;
					open_value();
					scan_phase = PH_VALSTART;
				end else if (crlf) begin
					scan_phase = PH_STOP;
				end else begin
					kw_set = 7'h7F;
					pos = 4'd0;
					kw_set = prune(kw_set, GRP_KEYWORD, 7, c);
					scan_phase = PH_NAME;
				end
			end
			PH_NAME: begin
				if (blank) begin
					settle_name();
					scan_phase = PH_AFTERNAME;
				end else if (c == CH_EQ) begin
					settle_name();
					open_value();
					scan_phase = PH_VALSTART;
				end else if (crlf) begin
					scan_phase = PH_STOP;
				end else begin
					kw_set = prune(kw_set, GRP_KEYWORD, 7, c);
				end
			end
			PH_AFTERNAME: begin
				if (blank) begin
				end else if (c == CH_EQ) begin
					open_value();
					scan_phase = PH_VALSTART;
				end else begin
					scan_phase = PH_STOP;
				end
			end
			PH_VALSTART: begin
				if (blank) begin
				end else if (c == CH_QUOTE) begin
					scan_phase = PH_QUOTED;
				end else if (c == CH_COMMA || crlf) begin
					close_value();
					scan_phase = (c == CH_COMMA) ? PH_NAMESKIP : PH_STOP;
				end else begin
					take_value(c);
					scan_phase = PH_BARE;
				end
			end
			PH_QUOTED: begin
				if (c == CH_QUOTE) begin
					close_value();
					scan_phase = PH_NAMESKIP;
				end else begin
					take_value(c);
				end
			end
			PH_BARE: begin
				if (c == CH_COMMA || blank || crlf) begin
					close_value();
					scan_phase = crlf ? PH_STOP : PH_NAMESKIP;
				end else begin
					take_value(c);
				end
			end
			default: begin
			end
		endcase

		// Field end: flush a pending scheme or open value, else a bare done event
		if (eof) begin
			if (scan_phase == PH_LEAD || scan_phase == PH_SCHEME) begin
				note_scheme();
			end else if (scan_phase == PH_VALSTART || scan_phase == PH_QUOTED ||
					scan_phase == PH_BARE) begin
				if (step_event.have) begin
					step_event.vdone = 1'b1;
					step_event.ovf = val_ovf;
				end else begin
					close_value();
				end
			end
			if (!step_event.have) post_event(KIND_DONE, 3'd0, 8'd0, 1'b0, 1'b0);
			step_event.fdone = 1'b1;
			restart_scan();
		end
		if (step_event.have) pending_events.push_back(step_event);
	endfunction

	// ---------------------------------------------------------------- input side

	task automatic send_byte(input logic [7:0] c, input logic eof);
		int gap;
		gap = send_idle_en ? int'($urandom_range(0, 16)) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= c;
		end_of_field <= eof;
		do @(posedge clk); while (!in_ready);
		parse_header_byte(c, eof);
	endtask

	// Send a slice of the current field; the last byte of the field carries the end mark
	task automatic send_span(input int lo, input int hi);
		for (int i = lo; i <= hi; i++)
			send_byte(field_bytes[i], i == field_bytes.size() - 1);
	endtask

	task automatic send_field();
		send_span(0, field_bytes.size() - 1);
	endtask

	// Hold off input until every expected event is in and the pipe has emptied
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		value_limit = v;
	endtask

	// ---------------------------------------------------------------- field building

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) field_bytes.push_back(s[i]);
	endtask

	task automatic start_field(input string s);
		field_bytes.delete();
		push_text(s);
	endtask

	// Push a word with each letter in random case
	task automatic push_word(input string w);
		logic [7:0] c;
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
			field_bytes.push_back(c);
		end
	endtask

	task automatic push_random_word();
		repeat ($urandom_range(1, 7)) field_bytes.push_back(8'($urandom_range(97, 122)));
	endtask

	task automatic push_blank();
		field_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
	endtask

	// Near miss of a word: one letter short or one too many
	function automatic string mangle(string w);
		if ($urandom_range(0, 1) == 0 && w.len() > 1) return w.substr(0, w.len() - 2);
		return {w, "x"};
	endfunction

	function automatic logic [7:0] value_char(bit quoted);
		logic [7:0] c;
		do begin
			c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(33, 126));
		end while (quoted ? (c == CH_QUOTE) :
			(c == CH_COMMA || c == CH_SPACE || c == CH_TAB || c == CH_CR ||
			c == CH_LF || c == CH_QUOTE));
		return c;
	endfunction

	// Mostly well-formed fields with random content, some noise and broken pairs
	task automatic build_field();
		int np;
		int pick;
		int vlen;
		bit quoted;
		field_bytes.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) field_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 2)) push_blank();
		pick = $urandom_range(0, 5);
		if (pick <= 2) push_word(word_of(GRP_SCHEME, $urandom_range(0, 1)));
		else if (pick == 3) push_word(mangle(word_of(GRP_SCHEME, $urandom_range(0, 1))));
		else if (pick == 4) push_random_word();
		if ($urandom_range(0, 19) == 0) begin
			if (field_bytes.size() == 0) push_blank();
			return;
		end
		repeat ($urandom_range(1, 2)) push_blank();

		np = $urandom_range(0, 4);
		for (int i = 0; i < np; i++) begin
			pick = $urandom_range(0, 9);
			if (pick <= 6) push_word(word_of(GRP_KEYWORD, pick));
			else if (pick == 7) push_word(mangle(word_of(GRP_KEYWORD, $urandom_range(0, 6))));
			else if (pick == 8) push_random_word();
			if ($urandom_range(0, 9) == 0) push_blank();
			case ($urandom_range(0, 39))
				0: begin
				end
				1: field_bytes.push_back(CH_CR);
				default: field_bytes.push_back(CH_EQ);
			endcase
			if ($urandom_range(0, 9) == 0) push_blank();
			quoted = 1'($urandom_range(0, 1));
			if (quoted) field_bytes.push_back(CH_QUOTE);
			if (pick == 6) begin
				case ($urandom_range(0, 5))
					0, 1: push_word("true");
					2, 3: push_word("false");
					4: push_word(mangle(word_of(GRP_STALE, $urandom_range(0, 1))));
					default: begin
					end
				endcase
			end else begin
				vlen = ($urandom_range(0, 9) == 0) ? int'($urandom_range(7, 20)) :
					int'($urandom_range(0, 6));
				repeat (vlen) field_bytes.push_back(value_char(quoted));
			end
			// leave the last quote open now and then
			if (quoted && !(i == np - 1 && $urandom_range(0, 9) == 0))
				field_bytes.push_back(CH_QUOTE);
			if (i != np - 1) begin
				case ($urandom_range(0, 3))
					0: push_text(",");
					1: push_text(", ");
					2: push_text(" ,");
					default: push_text(" , ");
				endcase
			end
		end
		case ($urandom_range(0, 7))
			0: push_text("\r\n");
			1: push_text(",");
			default: begin
			end
		endcase
		if (field_bytes.size() == 0) push_blank();
	endtask

	// ---------------------------------------------------------------- tests

	// Short fields for the scheme cases, zero byte, CR in quotes, empty stale, no '='
	task automatic test_directed();
		field_bytes.delete();
		field_bytes.push_back(8'h00);
		send_field();
		start_field(" \t");
		send_field();
		start_field(" \nZ");
		send_field();
		start_field("bAsIc");
		send_field();
		start_field("Digest qop=\"\r");
		field_bytes.push_back(8'hFF);
		send_field();
		start_field("x stale=,nonce");
		send_field();
	endtask

	// Value limit at zero, one and the top, with overflow on each
	task automatic test_value_limits();
		write_limit(8'd0);
		start_field("Basic realm=ab");
		send_field();
		write_limit(8'd1);
		start_field("Digest nonce=\"xyz\",opaque=q");
		send_field();
		write_limit(8'd255);
		start_field("Basic domain=\"");
		repeat (257) field_bytes.push_back(value_char(1'b1));
		field_bytes.push_back(CH_QUOTE);
		send_field();
	endtask

	// Drain mid-field, then stall the result side long enough to back up the input
	task automatic test_backpressure();
		send_idle_en = 1'b0;
		start_field("Digest opaque=\"");
		repeat (40) field_bytes.push_back(value_char(1'b1));
		field_bytes.push_back(CH_QUOTE);
		send_span(0, 15);
		wait_idle();
		hold_cycles = LONG_HOLD;
		send_span(16, field_bytes.size() - 1);
		send_idle_en = 1'b1;
	endtask

	// Random fields across several limits and idle patterns
	task automatic test_random();
		logic [7:0] limits [NUM_PHASES];
		int sent;
		limits = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd127};
		limits[2] = 8'($urandom_range(2, 254));
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_limit(limits[p]);
			send_idle_en = (p != 1 && p != 3);
			recv_idle_en = (p != 2 && p != 3);
			sent = 0;
			while (sent < RANDOM_BYTES_PER_PHASE) begin
				build_field();
				sent += field_bytes.size();
				send_field();
			end
		end
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
	endtask

	// ---------------------------------------------------------------- result side

	task automatic check_result();
		hdr_event_t want;
		if (pending_events.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] event with none expected: kind %0d param %0d payload %02h",
					$realtime, event_kind, param_id, payload);
			return;
		end
		want = pending_events.pop_front();
		if (event_kind !== want.kind || param_id !== want.pid || payload !== want.pay ||
				value_done !== want.vdone || overflowed !== want.ovf ||
				field_done !== want.fdone) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] event mismatch", $realtime);
				$display("  expected kind %0d param %0d payload %02h vdone %0b ovf %0b fdone %0b",
					want.kind, want.pid, want.pay, want.vdone, want.ovf, want.fdone);
				$display("  actual   kind %0d param %0d payload %02h vdone %0b ovf %0b fdone %0b",
					event_kind, param_id, payload, value_done, overflowed, field_done);
			end
		end
	endtask

	// Accept result beats with random stalls, or one long hold when asked
	initial begin : result_side
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles != 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = recv_idle_en ? int'($urandom_range(0, 16)) : 0;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_result();
		end
	end

	// Abort when neither channel moves a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'd0;
		in_valid = 1'b0;
		data_byte = 8'd0;
		end_of_field = 1'b0;
		value_limit = 8'd127;
		restart_scan();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_value_limits();
		test_backpressure();
		test_random();
		wait_idle();

		if (mismatches == 0 && pending_events.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
